// ----- design/pqlm_pkg.sv -----
// ----------------------------------------------------------------------------
// pqlm_pkg
// Shared types, constants and helpers for the priority queue load monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package pqlm_pkg;

  localparam int NUM_CLASSES    = 3;
  localparam int CLASS_CAPACITY = 4096;
  localparam int TICK_BITS      = 24;
  localparam int CLASS_W        = $clog2(CLASS_CAPACITY + 1);
  localparam int TOTAL_W        = $clog2(NUM_CLASSES * CLASS_CAPACITY + 1);
  localparam int LOAD_W         = 7;
  localparam int PCT_FULL       = 100;
  localparam int OP_W           = 3;
  localparam int PRI_W          = 2;
  localparam int CLS_IDX_W      = $clog2(NUM_CLASSES);
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  // register index, taken from paddr word bit
  localparam logic REG_STRICT = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_TICK    = 3'd2,
    OP_COMPUTE = 3'd3,
    OP_CLR_WIN = 3'd4,
    OP_CLR_ALL = 3'd5
  } op_e;

  typedef struct packed {
    logic             commit;
    logic [OP_W-1:0]  op;
    logic [PRI_W-1:0] pri;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [CLS_IDX_W-1:0] idx;
    logic [LOAD_W-1:0]    val;
  } load_wr_t;

  typedef struct packed {
    logic                                 status;
    logic [CLASS_W-1:0]                   class_count;
    logic [TOTAL_W-1:0]                   total;
    logic [NUM_CLASSES-1:0][LOAD_W-1:0]   load;
  } res_t;

  // saturating tick increment
  function automatic logic [TICK_BITS-1:0] bump(input logic [TICK_BITS-1:0] v);
    return (v == TICK_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- design/priority_queue_load_monitor.sv -----
// ----------------------------------------------------------------------------
// priority_queue_load_monitor
// Packet counts, busy sampling and load percentages for three priority classes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   operation: add, remove, sample tick, compute loads, clear window, clear
//   all. Each transaction yields exactly one result transaction on the output
//   channel (out_valid_o / out_stall_i), held in a single output register.
//   Every operation except compute loads updates the counters in the
//   accepting cycle; its result is registered in the output register, and
//   a new transaction is taken every cycle while the output is drained.
//   Compute loads runs a bit-serial divider per class, one quotient bit a
//   cycle, with no division for an empty window. Its result is valid once
//   the last class is divided, in_stall_o high meanwhile.
//   A stalled receiver holds the result; the input is stalled while the
//   output register is full and not being taken, and while loads are computed.
//   Reset clears all counters, loads and both configuration registers.
//   Configuration: APB registers strict_priority at 0x0, load_threshold at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_load_monitor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pqlm_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pqlm_pkg::DATA_W-1:0]    pwdata,
  output logic      [pqlm_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  // operation channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pqlm_pkg::OP_W-1:0]      operation_i,
  input  wire logic [pqlm_pkg::PRI_W-1:0]     priority_req_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                status_o,
  output logic [pqlm_pkg::CLASS_W-1:0]        class_count_o,
  output logic [pqlm_pkg::TOTAL_W-1:0]        total_count_o,
  output logic [pqlm_pkg::LOAD_W-1:0]         load_high_o,
  output logic [pqlm_pkg::LOAD_W-1:0]         load_mid_o,
  output logic [pqlm_pkg::LOAD_W-1:0]         load_low_o
);
  import pqlm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_WAIT   = 4'b0100,
    S_REPORT = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CLS_IDX_W-1:0]  cls_q, cls_d;
  logic [PRI_W-1:0]      pri_q, pri_d;
  logic                  strict_q;
  logic [CLASS_W-1:0]    thresh_q;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  accept;
  logic                  is_compute;
  logic                  out_load;
  logic                  cfg_wr;
  logic                  div_start;
  logic                  div_done;
  logic [LOAD_W-1:0]     div_quot;
  logic [TICK_BITS-1:0]  busy_sel;
  cmd_t                  cmd;
  load_wr_t              load_wr;
  res_t                  res;
  res_t                  res_q;
  logic [NUM_CLASSES-1:0][TICK_BITS-1:0] busy;
  logic [TICK_BITS-1:0]  window;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, write on the access phase
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      thresh_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_STRICT: strict_q <= pwdata[0];
        REG_THRESH: thresh_q <= pwdata[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_STRICT: prdata = {{(DATA_W-1){1'b0}}, strict_q};
      REG_THRESH: prdata = {{(DATA_W-CLASS_W){1'b0}}, thresh_q};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: take a transaction only when idle and the output slot frees
  // --------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_compute = (operation_i == OP_COMPUTE);

  // compute loads leaves the counters alone; the report step reads them back
  assign cmd.commit = accept && !is_compute;
  assign cmd.op     = (state_q == S_REPORT) ? OP_COMPUTE : operation_i;
  assign cmd.pri    = (state_q == S_REPORT) ? pri_q : priority_req_i;

  // --------------------------------------------------------------------------
  // Sequencer for compute loads: one division per class, in class order
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    cls_d     = cls_q;
    pri_d     = pri_q;
    div_start = 1'b0;
    load_wr   = '0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_compute) begin
            pri_d   = priority_req_i;
            cls_d   = '0;
            state_d = S_LOAD;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      S_LOAD: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          load_wr.we  = 1'b1;
          load_wr.idx = cls_q;
          load_wr.val = div_quot;
          if (cls_q == CLS_IDX_W'(NUM_CLASSES - 1)) begin
            state_d = S_REPORT;
          end else begin
            cls_d   = cls_q + 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      S_REPORT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cls_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    if (out_load) res_q <= res;
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_comb begin
    busy_sel = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls_q == CLS_IDX_W'(c)) busy_sel = busy[c];
    end
  end

  pqlm_stats u_stats (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .strict_i  (strict_q),
    .thresh_i  (thresh_q),
    .load_wr_i (load_wr),
    .busy_o    (busy),
    .window_o  (window),
    .res_o     (res)
  );

  // window and busy counts cannot move while the sequencer runs
  pqlm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .busy_i   (busy_sel),
    .window_i (window),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign class_count_o = res_q.class_count;
  assign total_count_o = res_q.total;
  assign load_high_o   = res_q.load[0];
  assign load_mid_o    = res_q.load[1];
  assign load_low_o    = res_q.load[2];

`ifndef SYNTH
  // a compute transaction must hold off the next one
  a_compute_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_compute) |=> in_stall_o)
    else $error("input taken while loads are being computed");

  // divider finishes only when the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT))
    else $error("divider result outside the wait step");

  // a load never exceeds a full percentage
  a_load_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_quot <= LOAD_W'(PCT_FULL)))
    else $error("load percentage out of range");
`endif

endmodule

`default_nettype wire

// ----- design/pqlm_div.sv -----
// ----------------------------------------------------------------------------
// pqlm_div
// Bit-serial restoring divider: floor(100*busy/window), one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pqlm_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [pqlm_pkg::TICK_BITS-1:0] busy_i,
  input  wire logic [pqlm_pkg::TICK_BITS-1:0] window_i,
  output logic                                done_o,
  output logic [pqlm_pkg::LOAD_W-1:0]         quot_o
);
  import pqlm_pkg::*;

  localparam int PROD_W = TICK_BITS + LOAD_W;
  localparam int CNT_W  = $clog2(LOAD_W);

  logic [TICK_BITS-1:0] rem_q, rem_d;
  logic [LOAD_W-1:0]    dig_q, dig_d;
  logic [LOAD_W-1:0]    quot_q, quot_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [PROD_W-1:0]    prod;
  logic [TICK_BITS-1:0] prod_hi;
  logic [TICK_BITS:0]   trial;
  logic                 ge;

  // x100 as shift-and-add: 64 + 32 + 4
  assign prod    = {1'b0, busy_i, 6'b0} + {2'b0, busy_i, 5'b0} + {5'b0, busy_i, 2'b0};
  assign prod_hi = prod[PROD_W-1:LOAD_W];
  assign trial   = {rem_q, dig_q[LOAD_W-1]};
  assign ge      = trial >= {1'b0, window_i};

  always_comb begin
    rem_d  = rem_q;
    dig_d  = dig_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = prod_hi;
      dig_d  = prod[LOAD_W-1:0];
      quot_d = '0;
      cnt_d  = CNT_W'(LOAD_W - 1);
      if (window_i == '0) begin
        done_d = 1'b1;
      end else if (prod_hi >= window_i) begin
        // quotient would not fit in LOAD_W bits
        quot_d = LOAD_W'(PCT_FULL);
        done_d = 1'b1;
      end else begin
        run_d = 1'b1;
      end
    end else if (run_q) begin
      rem_d  = ge ? TICK_BITS'(trial - {1'b0, window_i}) : trial[TICK_BITS-1:0];
      dig_d  = {dig_q[LOAD_W-2:0], 1'b0};
      quot_d = {quot_q[LOAD_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dig_q  <= dig_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = (quot_q > LOAD_W'(PCT_FULL)) ? LOAD_W'(PCT_FULL) : quot_q;

endmodule

`default_nettype wire

// ----- design/pqlm_stats.sv -----
// ----------------------------------------------------------------------------
// pqlm_stats
// Packet counters, busy-tick counters, window tick total and stored loads.
// ----------------------------------------------------------------------------
`default_nettype none

module pqlm_stats (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire pqlm_pkg::cmd_t                                   cmd_i,
  input  wire logic                                             strict_i,
  input  wire logic [pqlm_pkg::CLASS_W-1:0]                     thresh_i,
  input  wire pqlm_pkg::load_wr_t                               load_wr_i,
  output logic [pqlm_pkg::NUM_CLASSES-1:0][pqlm_pkg::TICK_BITS-1:0] busy_o,
  output logic [pqlm_pkg::TICK_BITS-1:0]                        window_o,
  output pqlm_pkg::res_t                                        res_o
);
  import pqlm_pkg::*;

  logic [NUM_CLASSES-1:0][CLASS_W-1:0]   class_q, class_d;
  logic [TOTAL_W-1:0]                    total_q, total_d;
  logic [NUM_CLASSES-1:0][TICK_BITS-1:0] busy_q, busy_d;
  logic [TICK_BITS-1:0]                  win_q, win_d;
  logic [NUM_CLASSES-1:0][LOAD_W-1:0]    load_q, load_d;
  logic [NUM_CLASSES-1:0]                over;
  logic [NUM_CLASSES-1:0]                busy_now;
  logic                                  any_over;
  logic [CLASS_W-1:0]                    sel_now, sel_next;
  logic                                  pri_ok;
  logic                                  status;

  always_comb begin
    pri_ok  = cmd_i.pri < PRI_W'(NUM_CLASSES);
    sel_now = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cmd_i.pri == PRI_W'(c)) sel_now = class_q[c];
    end
    // strict mode: a higher class over threshold makes lower ones busy
    for (int c = 0; c < NUM_CLASSES; c++) begin
      over[c] = class_q[c] > thresh_i;
    end
    any_over = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      busy_now[c] = over[c] || (strict_i && any_over);
      any_over    = any_over || over[c];
    end
  end

  always_comb begin
    class_d = class_q;
    total_d = total_q;
    busy_d  = busy_q;
    win_d   = win_q;
    load_d  = load_q;
    status  = 1'b0;
    if (cmd_i.commit) begin
      case (cmd_i.op)
        OP_ADD: begin
          if (pri_ok && (sel_now < CLASS_W'(CLASS_CAPACITY))) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              if (cmd_i.pri == PRI_W'(c)) class_d[c] = class_q[c] + 1'b1;
            end
            total_d = total_q + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (pri_ok) begin
            if (sel_now == '0) begin
              status = 1'b1;
            end else begin
              for (int c = 0; c < NUM_CLASSES; c++) begin
                if (cmd_i.pri == PRI_W'(c)) class_d[c] = class_q[c] - 1'b1;
              end
              if (total_q != '0) total_d = total_q - 1'b1;
            end
          end
        end
        OP_TICK: begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (busy_now[c]) busy_d[c] = bump(busy_q[c]);
          end
          win_d = bump(win_q);
        end
        OP_CLR_WIN: begin
          busy_d = '0;
          win_d  = '0;
        end
        OP_CLR_ALL: begin
          class_d = '0;
          total_d = '0;
          busy_d  = '0;
          win_d   = '0;
          load_d  = '0;
        end
        default: ;
      endcase
    end
    if (load_wr_i.we) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (load_wr_i.idx == CLS_IDX_W'(c)) load_d[c] = load_wr_i.val;
      end
    end
    sel_next = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cmd_i.pri == PRI_W'(c)) sel_next = class_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_q <= '0;
      total_q <= '0;
      busy_q  <= '0;
      win_q   <= '0;
      load_q  <= '0;
    end else begin
      class_q <= class_d;
      total_q <= total_d;
      busy_q  <= busy_d;
      win_q   <= win_d;
      load_q  <= load_d;
    end
  end

  assign busy_o             = busy_q;
  assign window_o           = win_q;
  assign res_o.status       = status;
  assign res_o.class_count  = pri_ok ? sel_next : '0;
  assign res_o.total        = total_d;
  assign res_o.load         = load_d;

endmodule

`default_nettype wire

// ----- tb/sv/pqlm_load_checker.sv -----
// ----------------------------------------------------------------------------
// pqlm_load_checker
// Watches the monitor's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
module pqlm_load_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes, observed only
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [pqlm_pkg::ADDR_W-1:0]    paddr,
  input  logic [pqlm_pkg::DATA_W-1:0]    pwdata,
  // operation channel
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [pqlm_pkg::OP_W-1:0]      operation_i,
  input  logic [pqlm_pkg::PRI_W-1:0]     priority_req_i,
  // result channel
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           status_i,
  input  logic [pqlm_pkg::CLASS_W-1:0]   class_count_i,
  input  logic [pqlm_pkg::TOTAL_W-1:0]   total_count_i,
  input  logic [pqlm_pkg::LOAD_W-1:0]    load_high_i,
  input  logic [pqlm_pkg::LOAD_W-1:0]    load_mid_i,
  input  logic [pqlm_pkg::LOAD_W-1:0]    load_low_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pqlm_pkg::*;

  localparam int unsigned           REPORT_LIMIT = 10;
  localparam logic [TICK_BITS-1:0]  TICK_TOP     = '1;

  typedef struct packed {
    logic               status;
    logic [CLASS_W-1:0] class_count;
    logic [TOTAL_W-1:0] total;
    logic [LOAD_W-1:0]  load_high;
    logic [LOAD_W-1:0]  load_mid;
    logic [LOAD_W-1:0]  load_low;
  } outcome_t;

  // shadow copy of the monitor's registers and counters
  logic                 strict_mode;
  logic [CLASS_W-1:0]   thresh;
  logic [CLASS_W-1:0]   held [NUM_CLASSES];
  logic [TOTAL_W-1:0]   held_total;
  logic [TICK_BITS-1:0] busy [NUM_CLASSES];
  logic [TICK_BITS-1:0] window;
  logic [LOAD_W-1:0]    pct [NUM_CLASSES];

  outcome_t             due_outcomes [$];
  int unsigned          fails = 0;
  int unsigned          checked = 0;

  function automatic logic [TICK_BITS-1:0] sat_tick(input logic [TICK_BITS-1:0] v);
    return (v >= TICK_TOP) ? TICK_TOP : v + 1'b1;
  endfunction

  // applies one operation to the shadow state and returns its result
  function automatic outcome_t advance_monitor(input logic [OP_W-1:0]  op,
                                               input logic [PRI_W-1:0] pri);
    outcome_t        o;
    logic            known;
    logic            over;
    logic            any_over;
    longint unsigned share;
    o        = '0;
    known    = (pri < NUM_CLASSES);
    any_over = 1'b0;
    case (op)
      OP_ADD: begin
        if (known && held[pri] < CLASS_CAPACITY) begin
          held[pri]  = held[pri] + 1'b1;
          held_total = held_total + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (known) begin
          if (held[pri] == '0) begin
            o.status = 1'b1;
          end else begin
            held[pri] = held[pri] - 1'b1;
            if (held_total != '0) held_total = held_total - 1'b1;
          end
        end
      end
      OP_TICK: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          over = (held[c] > thresh);
          if (over || (strict_mode && any_over)) busy[c] = sat_tick(busy[c]);
          any_over = any_over | over;
        end
        window = sat_tick(window);
      end
      OP_COMPUTE: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          if (window == '0) begin
            pct[c] = '0;
          end else begin
            share  = busy[c];
            share  = (share * PCT_FULL) / window;
            pct[c] = (share > PCT_FULL) ? LOAD_W'(PCT_FULL) : share[LOAD_W-1:0];
          end
        end
      end
      OP_CLR_WIN: begin
        foreach (busy[c]) busy[c] = '0;
        window = '0;
      end
      OP_CLR_ALL: begin
        foreach (held[c]) begin
          held[c] = '0;
          busy[c] = '0;
          pct[c]  = '0;
        end
        held_total = '0;
        window     = '0;
      end
      default: ;
    endcase
    o.class_count = known ? held[pri] : '0;
    o.total       = held_total;
    o.load_high   = pct[0];
    o.load_mid    = pct[1];
    o.load_low    = pct[2];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      strict_mode = 1'b0;
      thresh      = '0;
      foreach (held[c]) begin
        held[c] = '0;
        busy[c] = '0;
        pct[c]  = '0;
      end
      held_total = '0;
      window     = '0;
      due_outcomes.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      // result first: it belongs to an operation taken at an earlier edge
      if (out_valid_i && !out_stall_i) begin
        got = {status_i, class_count_i, total_count_i, load_high_i, load_mid_i, load_low_i};
        checked++;
        if (due_outcomes.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%t: unexpected result: st %0d cls %0d tot %0d loads %0d/%0d/%0d",
                     $realtime, got.status, got.class_count, got.total,
                     got.load_high, got.load_mid, got.load_low);
        end else begin
          want = due_outcomes.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%t: mismatch, expected st %0d cls %0d tot %0d loads %0d/%0d/%0d",
                       $realtime, want.status, want.class_count, want.total,
                       want.load_high, want.load_mid, want.load_low);
              $display("%t:            got      st %0d cls %0d tot %0d loads %0d/%0d/%0d",
                       $realtime, got.status, got.class_count, got.total,
                       got.load_high, got.load_mid, got.load_low);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_STRICT: strict_mode = pwdata[0];
          REG_THRESH: thresh      = pwdata[CLASS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        due_outcomes.push_back(advance_monitor(operation_i, priority_req_i));
      pending_o    <= due_outcomes.size();
      fail_count_o <= fails;
      checked_o    <= checked;
    end
  end

endmodule

// ----- tb/sv/priority_queue_load_monitor_test.sv -----
// ----------------------------------------------------------------------------
// priority_queue_load_monitor_test
// Stimulus and verdict for the priority queue load monitor.
// Directed corner cases, fills of every class around the threshold, then
// random phases under several register settings; a separate checker predicts
// and compares every result transaction.
// ----------------------------------------------------------------------------
module priority_queue_load_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pqlm_pkg::*;

  // slowest legal run: ~1300 operations, each at most a full idle gap, a full
  // result stall and a compute, plus drains; the limit is set well above that
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned MAX_GAP       = 14;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 225;
  // packets per class in the threshold fills
  localparam int unsigned FILL_COUNT    = 40;

  // operation codes the block does not use; must be ignored
  localparam logic [OP_W-1:0]  OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_B = 3'd7;
  // priority classes; the fourth code names no class
  localparam logic [PRI_W-1:0] PRI_HIGH   = 2'd0;
  localparam logic [PRI_W-1:0] PRI_MID    = 2'd1;
  localparam logic [PRI_W-1:0] PRI_LOW    = 2'd2;
  localparam logic [PRI_W-1:0] PRI_NONE   = 2'd3;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [ADDR_W-1:0]  paddr          = '0;
  logic [DATA_W-1:0]  pwdata         = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [OP_W-1:0]    operation_i    = '0;
  logic [PRI_W-1:0]   priority_req_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic               status_o;
  logic [CLASS_W-1:0] class_count_o;
  logic [TOTAL_W-1:0] total_count_o;
  logic [LOAD_W-1:0]  load_high_o;
  logic [LOAD_W-1:0]  load_mid_o;
  logic [LOAD_W-1:0]  load_low_o;

  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        checked;
  int unsigned        sent   = 0;
  int unsigned        cycles = 0;
  // cleared during stretches where neither side should idle
  bit                 gaps_on = 1'b1;

  priority_queue_load_monitor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .class_count_o  (class_count_o),
    .total_count_o  (total_count_o),
    .load_high_o    (load_high_o),
    .load_mid_o     (load_mid_o),
    .load_low_o     (load_low_o)
  );

  pqlm_load_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .operation_i    (operation_i),
    .priority_req_i (priority_req_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .class_count_i  (class_count_o),
    .total_count_i  (total_count_o),
    .load_high_i    (load_high_o),
    .load_mid_i     (load_mid_o),
    .load_low_i     (load_low_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // idle/stall length for one transaction; at least a third of draws give none at all
  function automatic int unsigned draw_gap();
    if (!gaps_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // result side: after each accepted result, stall for a drawn number of cycles.
  // The countdown runs whether or not a result is waiting, so stalls land on
  // every phase of the divider too.
  initial begin : result_drain
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) hold--;
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) hold = draw_gap();
    end
  end

  // one operation transaction; valid stays high into the next call when no gap
  task automatic send_op(input logic [OP_W-1:0] op, input logic [PRI_W-1:0] pri);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    priority_req_i <= pri;
    // accepted at the first edge that sees no stall
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({reg_idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // packet traffic dominates, ticks next; computes, clears, spare codes and
  // the classless priority code are kept rare
  task automatic random_op();
    int unsigned     r;
    logic [OP_W-1:0] op;
    logic [PRI_W-1:0] pri;
    r   = $urandom_range(0, 99);
    pri = ($urandom_range(0, 19) == 0) ? PRI_NONE : PRI_W'($urandom_range(0, 2));
    if (r < 36)      op = OP_ADD;
    else if (r < 60) op = OP_REMOVE;
    else if (r < 82) op = OP_TICK;
    else if (r < 89) op = OP_COMPUTE;
    else if (r < 93) op = OP_CLR_WIN;
    else if (r < 95) op = OP_CLR_ALL;
    else if (r < 98) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
    else             op = OP_W'($urandom_range(0, 7));
    send_op(op, pri);
  endtask

  task automatic random_phase(input logic strict, input int unsigned thr,
                              input int unsigned count);
    drain_results();
    write_reg(REG_STRICT, DATA_W'(strict));
    write_reg(REG_THRESH, DATA_W'(thr));
    repeat (count) random_op();
  endtask

  initial begin : stimulus
    // reset held from time zero, released away from the clock edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed: relaxed mode, threshold zero ----
    write_reg(REG_STRICT, '0);
    write_reg(REG_THRESH, '0);
    send_op(OP_COMPUTE, PRI_HIGH);   // empty window gives zero loads
    send_op(OP_REMOVE,  PRI_HIGH);   // remove from an empty class is refused
    send_op(OP_ADD,     PRI_NONE);   // no such class: nothing happens
    send_op(OP_REMOVE,  PRI_NONE);
    send_op(OP_SPARE_A, PRI_MID);
    send_op(OP_SPARE_B, PRI_LOW);
    send_op(OP_ADD,     PRI_HIGH);
    send_op(OP_ADD,     PRI_MID);
    send_op(OP_ADD,     PRI_MID);
    send_op(OP_ADD,     PRI_LOW);
    send_op(OP_TICK,    PRI_MID);
    send_op(OP_REMOVE,  PRI_MID);
    send_op(OP_REMOVE,  PRI_HIGH);
    send_op(OP_TICK,    PRI_LOW);
    send_op(OP_COMPUTE, PRI_MID);
    send_op(OP_CLR_WIN, PRI_LOW);    // loads and counts survive
    send_op(OP_COMPUTE, PRI_HIGH);   // window empty again
    send_op(OP_TICK,    PRI_HIGH);
    send_op(OP_COMPUTE, PRI_LOW);
    send_op(OP_CLR_ALL, PRI_MID);
    send_op(OP_TICK,    PRI_HIGH);
    send_op(OP_COMPUTE, PRI_NONE);

    // ---- directed: strict mode drags the lower classes along ----
    drain_results();
    write_reg(REG_STRICT, 32'd1);
    send_op(OP_ADD,     PRI_HIGH);
    send_op(OP_TICK,    PRI_LOW);
    send_op(OP_COMPUTE, PRI_LOW);

    // ---- threshold edge: classes filled exactly to the threshold, then past ----
    drain_results();
    write_reg(REG_THRESH, DATA_W'(FILL_COUNT));
    send_op(OP_CLR_ALL, PRI_HIGH);
    gaps_on = 1'b0;
    repeat (FILL_COUNT) send_op(OP_ADD, PRI_HIGH);
    repeat (3) send_op(OP_TICK, PRI_HIGH);    // class at the threshold is not above it
    send_op(OP_COMPUTE, PRI_HIGH);
    drain_results();
    write_reg(REG_THRESH, DATA_W'(FILL_COUNT - 1));
    repeat (3) send_op(OP_TICK, PRI_MID);     // now over; strict marks all busy
    send_op(OP_COMPUTE, PRI_LOW);
    repeat (FILL_COUNT) send_op(OP_ADD, PRI_MID);
    repeat (FILL_COUNT) send_op(OP_ADD, PRI_LOW);
    repeat (5) send_op(OP_TICK, PRI_LOW);
    send_op(OP_COMPUTE, PRI_HIGH);
    repeat (3) send_op(OP_REMOVE, PRI_LOW);
    send_op(OP_TICK, PRI_MID);
    send_op(OP_COMPUTE, PRI_MID);
    send_op(OP_CLR_ALL, PRI_LOW);
    gaps_on = 1'b1;

    // ---- random phases over several register settings ----
    random_phase(1'b0, 0, PHASE_ITEMS);
    gaps_on = 1'b0;                         // back-to-back stretch
    random_phase(1'b1, 2, PHASE_ITEMS);
    gaps_on = 1'b1;
    random_phase(1'b0, $urandom_range(1, 10), PHASE_ITEMS);
    random_phase(1'b1, $urandom_range(0, 15), PHASE_ITEMS);
    random_phase(1'($urandom_range(0, 1)), $urandom_range(0, 6), PHASE_ITEMS);

    drain_results();
    $display("Drove %0d operations: corner cases, threshold fills, %0d random phases",
             sent, RANDOM_PHASES);
    $display("Compared %0d result transactions, %0d mismatched", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- priority_queue_load_monitor.f -----
design/pqlm_pkg.sv
design/pqlm_div.sv
design/pqlm_stats.sv
design/priority_queue_load_monitor.sv
tb/sv/pqlm_load_checker.sv
tb/sv/priority_queue_load_monitor_test.sv
